@@ hw/rtl/mpi_pkg.sv @@
// shared types and constants for the modular power / inverse core
// no dependencies; imported by mpi_mulmod and modular_power_and_inverse_core
package mpi_pkg;

  // arithmetic word width, 8 to 32
  localparam int WORD_WIDTH = 32;
  localparam int CNT_W      = $clog2(WORD_WIDTH);

  // stream field layout
  localparam int FIELD_W    = 32;
  localparam int BASE_LSB   = 0;
  localparam int EXP_LSB    = FIELD_W;
  localparam int MOD_LSB    = 2 * FIELD_W;
  localparam int IN_DATA_W  = 3 * FIELD_W;
  localparam int OUT_DATA_W = FIELD_W;

  localparam logic OP_POWER   = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  typedef logic [WORD_WIDTH-1:0] word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED,
    S_REDW,
    S_GCD,
    S_STEP,
    S_MUL,
    S_MULW,
    S_SQR,
    S_SQRW,
    S_FIN
  } state_t;

  // request to the bit-serial modular multiplier
  typedef struct packed {
    logic  start;
    word_t x;      // multiplier, consumed msb first
    word_t y;      // addend, must be below m
    word_t m;
  } mul_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;   // one-cycle pulse, product valid with it and after
    word_t product;
  } mul_rsp_t;

endpackage

@@ hw/rtl/mpi_mulmod.sv @@
// bit-serial modular multiplier: x*y mod m, one bit of x per cycle
// depends on mpi_pkg
module mpi_mulmod (
  input  logic              clk,
  input  logic              rst_n,
  input  mpi_pkg::mul_req_t req,
  output mpi_pkg::mul_rsp_t rsp
);
  import mpi_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  word_t             x_r, x_nxt;
  word_t             y_r, y_nxt;
  word_t             m_r, m_nxt;
  word_t             acc_r, acc_nxt;

  logic [WORD_WIDTH+1:0] sum;
  logic [WORD_WIDTH+1:0] m1;
  logic [WORD_WIDTH+1:0] m2;
  logic [WORD_WIDTH+1:0] red;

  // 2*acc + bit*y stays below 3m, so at most two subtractions of m
  always_comb begin
    m1  = {2'b00, m_r};
    m2  = {1'b0, m_r, 1'b0};
    sum = {1'b0, acc_r, 1'b0} + (x_r[WORD_WIDTH-1] ? {2'b00, y_r} : '0);
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    m_nxt    = m_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = req.x;
      y_nxt    = req.y;
      m_nxt    = req.m;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = red[WORD_WIDTH-1:0];
      x_nxt   = {x_r[WORD_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WORD_WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.busy    = busy_r;
  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule

@@ hw/rtl/modular_power_and_inverse_core.sv @@
// modular power and Fermat inverse core, streaming in and out
// depends on mpi_pkg and mpi_mulmod
//
// Each request carries an operation in in_tuser (0 = base^exponent mod
// modulus, 1 = inverse as base^(modulus-2) mod modulus) and base, exponent and
// modulus in in_tdata. The answer comes back as one result with the value in
// out_tdata and a no-inverse flag in out_tuser; the flag is set, and the value
// is 0, when an inverse is asked for and gcd(base, modulus) is not 1. The value
// is a true inverse only for a prime modulus. A modulus of 0 or 1 answers 0 at
// once (flag = operation for modulus 0). All products come from one bit-serial
// shift-add modular multiplier, and that multiplier sets the rate: the base is
// first reduced with one product, then each exponent bit below the highest set
// one costs a square plus, for a set bit, a multiply, and the highest set bit
// costs a multiply only. An inverse also runs a binary gcd. One request is in
// work at a time; a new one is taken as soon as the previous result sits in the
// output register.
module modular_power_and_inverse_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mpi_pkg::IN_DATA_W-1:0] in_tdata,   // base, exponent, modulus
  input  logic                          in_tuser,   // operation
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mpi_pkg::OUT_DATA_W-1:0] out_tdata, // result
  output logic                          out_tuser   // no_inverse
);
  import mpi_pkg::*;

  state_t state_r, state_nxt;

  // working registers
  logic  op_r, op_nxt;
  logic  flag_r, flag_nxt;
  word_t mod_r, mod_nxt;
  word_t b_r, b_nxt;       // running base power
  word_t e_r, e_nxt;       // remaining exponent
  word_t acc_r, acc_nxt;   // running product
  word_t res_r, res_nxt;
  word_t u_r, u_nxt;       // gcd operands
  word_t v_r, v_nxt;

  // output register
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                  out_tuser_r, out_tuser_nxt;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic  in_acc;
  word_t in_base;
  word_t in_exp;
  word_t in_mod;
  logic  mod_small;
  logic  gcd_end;
  logic  gcd_one;
  logic  both_even;
  logic  out_free;

  mpi_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_base   = in_tdata[BASE_LSB +: WORD_WIDTH];
  assign in_exp    = in_tdata[EXP_LSB +: WORD_WIDTH];
  assign in_mod    = in_tdata[MOD_LSB +: WORD_WIDTH];
  // modulus 0 or 1 answers without any arithmetic
  assign mod_small = (in_mod[WORD_WIDTH-1:1] == '0);

  // binary gcd: done when u reaches zero, coprime when v ends at one
  assign gcd_end   = (u_r == '0);
  assign gcd_one   = (v_r == word_t'(1));
  assign both_even = !u_r[0] && !v_r[0];
  // the result register is free or being drained this cycle
  assign out_free  = !out_tvalid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = mod_small ? S_FIN : S_RED;
        end
      end
      S_RED:  state_nxt = S_REDW;
      S_REDW: begin
        if (mul_rsp.done) begin
          state_nxt = (op_r == OP_INVERSE) ? S_GCD : S_STEP;
        end
      end
      S_GCD: begin
        if (gcd_end) begin
          state_nxt = gcd_one ? S_STEP : S_FIN;
        end else if (both_even) begin
          state_nxt = S_FIN;
        end
      end
      S_STEP: begin
        if (e_r == '0) begin
          state_nxt = S_FIN;
        end else if (e_r[0]) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_SQR;
        end
      end
      S_MUL:  state_nxt = S_MULW;
      S_MULW: begin
        if (mul_rsp.done) begin
          // skip the trailing square once no exponent bits remain
          state_nxt = (e_r[WORD_WIDTH-1:1] == '0) ? S_STEP : S_SQR;
        end
      end
      S_SQR:  state_nxt = S_SQRW;
      S_SQRW: begin
        if (mul_rsp.done) begin
          state_nxt = S_STEP;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and multiplier requests
  always_comb begin
    op_nxt         = op_r;
    flag_nxt       = flag_r;
    mod_nxt        = mod_r;
    b_nxt          = b_r;
    e_nxt          = e_r;
    acc_nxt        = acc_r;
    res_nxt        = res_r;
    u_nxt          = u_r;
    v_nxt          = v_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    mul_req.start  = 1'b0;
    mul_req.x      = b_r;
    mul_req.y      = b_r;
    mul_req.m      = mod_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt   = in_tuser;
          mod_nxt  = in_mod;
          b_nxt    = in_base;
          e_nxt    = in_exp;
          acc_nxt  = word_t'(1);
          res_nxt  = '0;
          // modulus zero has no inverse; modulus one is coprime to all
          flag_nxt = (in_mod == '0) && (in_tuser == OP_INVERSE);
        end
      end
      S_RED: begin
        // base mod m as base * 1 mod m
        mul_req.start = 1'b1;
        mul_req.x     = b_r;
        mul_req.y     = word_t'(1);
      end
      S_REDW: begin
        if (mul_rsp.done) begin
          b_nxt = mul_rsp.product;
          u_nxt = mul_rsp.product;
          v_nxt = mod_r;
        end
      end
      S_GCD: begin
        if (gcd_end) begin
          if (gcd_one) begin
            e_nxt = mod_r - word_t'(2);
          end else begin
            flag_nxt = 1'b1;
          end
        end else if (both_even) begin
          flag_nxt = 1'b1;
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (u_r >= v_r) begin
          u_nxt = u_r - v_r;
        end else begin
          v_nxt = v_r - u_r;
        end
      end
      S_STEP: begin
        if (e_r == '0) begin
          res_nxt = acc_r;
        end
      end
      S_MUL: begin
        mul_req.start = 1'b1;
        mul_req.x     = acc_r;
        mul_req.y     = b_r;
      end
      S_MULW: begin
        if (mul_rsp.done) begin
          acc_nxt = mul_rsp.product;
          if (e_r[WORD_WIDTH-1:1] == '0) begin
            e_nxt = '0;
          end
        end
      end
      S_SQR: begin
        mul_req.start = 1'b1;
      end
      S_SQRW: begin
        if (mul_rsp.done) begin
          b_nxt = mul_rsp.product;
          e_nxt = e_r >> 1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_DATA_W'(res_r);
          out_tuser_nxt  = flag_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    flag_r      <= flag_nxt;
    mod_r       <= mod_nxt;
    b_r         <= b_nxt;
    e_r         <= e_nxt;
    acc_r       <= acc_nxt;
    res_r       <= res_nxt;
    u_r         <= u_nxt;
    v_r         <= v_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // the multiplier is never restarted while a product is in flight
  a_mul_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  // a missing inverse always answers zero
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("no_inverse with nonzero result");

  // finished results are fully reduced
  a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (res_r < mod_r || res_r == '0))
    else $error("result not below modulus");

  // the gcd operand v never collapses to zero
  a_gcd_v_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GCD) |-> (v_r != '0))
    else $error("gcd operand v reached zero");

endmodule
